[sv/bd_pkg.sv]
package bd_pkg;

    localparam int ITERATIONS   = 24;
    localparam int FRAC_BITS    = 16;

    localparam int IN_W         = 32;
    localparam int DIFF_W       = IN_W + 1;
    localparam int MAG_W        = IN_W;
    localparam int CORDIC_GUARD = 3;
    localparam int CORDIC_W     = DIFF_W + FRAC_BITS + CORDIC_GUARD;
    localparam int ANGLE_W      = 64;
    localparam int STEP_W       = $clog2(ITERATIONS);
    localparam int SQ_W         = 2 * MAG_W;
    localparam int RAD_SUM_W    = SQ_W + 1;
    localparam int ROOT_DIGITS  = MAG_W + 1;
    localparam int RAD_W        = 2 * ROOT_DIGITS;
    localparam int REM_W        = ROOT_DIGITS + 2;
    localparam int BEARING_W    = 32;
    localparam int DIST_W       = 33;
    localparam int WRAP_W       = ANGLE_W - 1;
    localparam int DEG_K_W      = 38;
    localparam int DEG_W        = 33;

    localparam int ANGLE_OUT_STAGES = 5;
    // front end (4) + root cells + rounding (2)
    localparam int PIPE_DEPTH = 6 + ROOT_DIGITS;
    localparam int BEAR_DLY   = PIPE_DEPTH - 2 - ITERATIONS - ANGLE_OUT_STAGES;

    localparam logic [ANGLE_W-1:0] PI_Q60         = 64'h3243F6A8885A308D;
    localparam logic [ANGLE_W-1:0] TWO_PI_Q60     = 64'h6487ED5110B4611A;
    localparam logic [ANGLE_W-1:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
    localparam logic [DEG_K_W-1:0] DEG_PER_RAD_Q32   = 38'd246083499208;
    localparam logic [DEG_W-1:0]   FULL_TURN_DEG_Q23 = 33'd3019898880;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] u;
        logic signed [CORDIC_W-1:0] v;
        logic signed [ANGLE_W-1:0]  z;
    } t_rot;

    typedef struct packed {
        logic [RAD_W-1:0]       rad;
        logic [REM_W-1:0]       rem;
        logic [ROOT_DIGITS-1:0] root;
    } t_root;

    typedef logic [ITERATIONS-1:0][ANGLE_W-1:0] t_atan_rom;

    // floor(2^e / d) by shift-subtract long division
    function automatic logic [63:0] pow2_div(input int e, input int d);
        logic [63:0] num;
        logic [63:0] quo;
        logic [63:0] rest;
        num  = 64'd1 << e;
        quo  = '0;
        rest = '0;
        for (int b = 63; b >= 0; b--) begin
            rest = {rest[62:0], num[b]};
            if (rest >= 64'(d)) begin
                rest   = rest - 64'(d);
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q60: Taylor series, each term truncated
    function automatic t_atan_rom build_atan_rom();
        t_atan_rom   rom;
        logic [63:0] acc;
        int          e;
        for (int i = 0; i < ITERATIONS; i++) begin
            acc = '0;
            if (i == 0) begin
                acc = QUARTER_PI_Q60;
            end else begin
                for (int k = 0; k < 32; k++) begin
                    e = 60 - i * (2 * k + 1);
                    if (e >= 0) begin
                        if (k[0]) begin
                            acc = acc - pow2_div(e, 2 * k + 1);
                        end else begin
                            acc = acc + pow2_div(e, 2 * k + 1);
                        end
                    end
                end
            end
            rom[i] = acc;
        end
        return rom;
    endfunction

    localparam t_atan_rom ATAN_ROM = build_atan_rom();

endpackage

[sv/bd_rot_cell.sv]
module bd_rot_cell (
    input  logic                      i_clk,
    input  logic                      i_ce,
    input  logic [bd_pkg::STEP_W-1:0] i_step,
    input  bd_pkg::t_rot              i_data,
    output bd_pkg::t_rot              o_data
);
    import bd_pkg::*;

    logic signed [CORDIC_W-1:0] w_u;
    logic signed [CORDIC_W-1:0] w_v;
    logic signed [CORDIC_W-1:0] w_us;
    logic signed [CORDIC_W-1:0] w_vs;
    logic signed [ANGLE_W-1:0]  w_atan;
    t_rot                       n_data;
    t_rot                       r_data;

    assign w_u    = i_data.u;
    assign w_v    = i_data.v;
    assign w_us   = w_u >>> i_step;
    assign w_vs   = w_v >>> i_step;
    assign w_atan = $signed(ATAN_ROM[i_step]);

    // turn toward v = 0; v of zero counts as positive
    always_comb begin
        if (!w_v[CORDIC_W-1]) begin
            n_data.u = w_u + w_vs;
            n_data.v = w_v - w_us;
            n_data.z = i_data.z + w_atan;
        end else begin
            n_data.u = w_u - w_vs;
            n_data.v = w_v + w_us;
            n_data.z = i_data.z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[sv/bd_root_cell.sv]
module bd_root_cell (
    input  logic          i_clk,
    input  logic          i_ce,
    input  bd_pkg::t_root i_data,
    output bd_pkg::t_root o_data
);
    import bd_pkg::*;

    logic [REM_W+1:0] w_trial;
    logic [REM_W+1:0] w_test;
    logic [REM_W+1:0] w_diff;
    logic             w_ge;
    t_root            n_data;
    t_root            r_data;

    // bring down the next two radicand bits, try root digit 1
    assign w_trial = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
    assign w_test  = {2'b00, i_data.root, 2'b01};
    assign w_ge    = (w_trial >= w_test);
    assign w_diff  = w_trial - w_test;

    always_comb begin
        n_data.rem  = w_ge ? w_diff[REM_W-1:0] : w_trial[REM_W-1:0];
        n_data.root = {i_data.root[ROOT_DIGITS-2:0], w_ge};
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

[sv/bd_angle_out.sv]
module bd_angle_out (
    input  logic                                i_clk,
    input  logic                                i_ce,
    input  logic                                i_unit,
    input  logic signed [bd_pkg::ANGLE_W-1:0]   i_angle,
    output logic        [bd_pkg::BEARING_W-1:0] o_bearing
);
    import bd_pkg::*;

    logic signed [ANGLE_W-1:0] w_add;
    logic signed [ANGLE_W-1:0] w_sub;
    logic        [WRAP_W-1:0]  n_wz;
    logic        [WRAP_W-1:0]  r_wz;
    logic        [ANGLE_W-1:0] w_rnd;
    logic        [BEARING_W-1:0] r_rad2;
    logic        [BEARING_W-1:0] r_rad3;
    logic        [BEARING_W-1:0] r_rad4;
    logic        [63:0]        r_p00;
    logic        [37:0]        r_p01;
    logic        [62:0]        r_p10;
    logic        [36:0]        r_p11;
    logic        [36:0]        r_p11_s3;
    logic        [64:0]        r_mid;
    logic        [DEG_K_W-1:0] w_deg_sum;
    logic        [DEG_W-1:0]   r_deg;
    logic        [DEG_W-1:0]   w_deg_wrap;
    logic        [BEARING_W-1:0] r_bearing;

    // wrap into one full turn
    assign w_add = i_angle + $signed(TWO_PI_Q60);
    assign w_sub = i_angle - $signed(TWO_PI_Q60);

    always_comb begin
        priority if (i_angle[ANGLE_W-1]) begin
            n_wz = w_add[WRAP_W-1:0];
        end else if (!w_sub[ANGLE_W-1]) begin
            n_wz = w_sub[WRAP_W-1:0];
        end else begin
            n_wz = i_angle[WRAP_W-1:0];
        end
    end

    assign w_rnd     = {1'b0, r_wz} + (64'd1 << 30);
    assign w_deg_sum = DEG_K_W'(r_p11_s3) + DEG_K_W'(r_mid[64:32]) + DEG_K_W'(16);
    assign w_deg_wrap = (r_deg >= FULL_TURN_DEG_Q23) ? (r_deg - FULL_TURN_DEG_Q23) : r_deg;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_wz     <= n_wz;
            // Q60 -> Q29 rounded, and the partial products of z * deg/rad
            r_rad2   <= w_rnd[62:31];
            r_p00    <= r_wz[31:0] * DEG_PER_RAD_Q32[31:0];
            r_p01    <= r_wz[31:0] * DEG_PER_RAD_Q32[37:32];
            r_p10    <= r_wz[62:32] * DEG_PER_RAD_Q32[31:0];
            r_p11    <= r_wz[62:32] * DEG_PER_RAD_Q32[37:32];
            r_rad3   <= r_rad2;
            r_mid    <= 65'(r_p00[63:32]) + 65'(r_p01) + 65'(r_p10);
            r_p11_s3 <= r_p11;
            r_rad4   <= r_rad3;
            // high word of the product, rounded to Q23
            r_deg    <= w_deg_sum[DEG_K_W-1:5];
            r_bearing <= i_unit ? w_deg_wrap[BEARING_W-1:0] : r_rad4;
        end
    end

    assign o_bearing = r_bearing;

endmodule

[sv/bearing_and_distance_between_points.sv]
// Result path: four front-end stages, the 33 square-root digit cells and two rounding
// stages ahead of the output register; the bearing side (24 rotation cells and a
// 5-stage unit converter) is delayed to match.
// Throughput: one beat per cycle while o_ready is high; the skid register behind the
// output register lets the pipeline run while a result waits, and o_ready drops only
// once it is full. Reset (synchronous, active low) clears the valid line, output and
// skid valid, and sets angle_unit to radians. Datapath registers are not cleared.
module bearing_and_distance_between_points (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [bd_pkg::IN_W-1:0]      i_first_x,
    input  logic signed [bd_pkg::IN_W-1:0]      i_first_y,
    input  logic signed [bd_pkg::IN_W-1:0]      i_second_x,
    input  logic signed [bd_pkg::IN_W-1:0]      i_second_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic        [bd_pkg::BEARING_W-1:0] o_bearing,
    output logic        [bd_pkg::DIST_W-1:0]    o_distance,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);
    import bd_pkg::*;

    logic                        w_ce;
    logic                        w_in_acc;
    logic                        r_angle_unit;
    logic [PIPE_DEPTH-1:0]       r_valid;
    logic [PIPE_DEPTH-1:0]       r_zero;
    logic signed [DIFF_W-1:0]    r_dx;
    logic signed [DIFF_W-1:0]    r_dy;
    logic signed [DIFF_W-1:0]    w_ndx;
    logic signed [DIFF_W-1:0]    w_ndy;
    logic [MAG_W-1:0]            r_mag_x;
    logic [MAG_W-1:0]            r_mag_y;
    logic signed [CORDIC_W-1:0]  w_u0;
    logic signed [CORDIC_W-1:0]  w_v0;
    t_rot                        r_rot0;
    logic [SQ_W-1:0]             r_sq_x;
    logic [SQ_W-1:0]             r_sq_y;
    logic [RAD_SUM_W-1:0]        r_rad_sum;
    t_rot                        w_rot [ITERATIONS+1];
    t_root                       w_root [ROOT_DIGITS+1];
    logic [ROOT_DIGITS-1:0]      r_rnd_root;
    logic                        r_rnd_up;
    logic [DIST_W-1:0]           r_dist;
    logic [BEARING_W-1:0]        w_bear_raw;
    logic [BEARING_W-1:0]        w_bear_last;
    logic                        w_last_valid;
    logic [BEARING_W-1:0]        w_last_bearing;
    logic                        r_out_valid;
    logic                        r_skid_valid;
    logic                        n_out_valid;
    logic                        n_skid_valid;
    logic [BEARING_W-1:0]        r_out_bearing;
    logic [DIST_W-1:0]           r_out_dist;
    logic [BEARING_W-1:0]        r_skid_bearing;
    logic [DIST_W-1:0]           r_skid_dist;
    logic                        w_load_out;
    logic                        w_load_skid;
    logic                        w_out_from_skid;

    // the pipeline advances whenever the skid register is free
    assign w_ce        = !r_skid_valid;
    assign o_ready     = w_ce;
    assign w_in_acc    = i_valid && w_ce;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_unit <= 1'b0;
        end else if (i_cfg_valid) begin
            r_angle_unit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ce) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], w_in_acc};
        end
    end

    assign w_ndx = -r_dx;
    assign w_ndy = -r_dy;
    assign w_u0  = {{CORDIC_GUARD{r_dy[DIFF_W-1]}}, r_dy, {FRAC_BITS{1'b0}}};
    assign w_v0  = {{CORDIC_GUARD{r_dx[DIFF_W-1]}}, r_dx, {FRAC_BITS{1'b0}}};

    // front end: difference, magnitude and CORDIC start, squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_zero  <= {r_zero[PIPE_DEPTH-2:0],
                        (i_first_x == i_second_x) && (i_first_y == i_second_y)};
            r_dx    <= DIFF_W'(i_first_x) - DIFF_W'(i_second_x);
            r_dy    <= DIFF_W'(i_first_y) - DIFF_W'(i_second_y);
            r_mag_x <= r_dx[DIFF_W-1] ? w_ndx[MAG_W-1:0] : r_dx[MAG_W-1:0];
            r_mag_y <= r_dy[DIFF_W-1] ? w_ndy[MAG_W-1:0] : r_dy[MAG_W-1:0];
            // left half plane: flip the vector and start from pi
            r_rot0.u <= r_dy[DIFF_W-1] ? -w_u0 : w_u0;
            r_rot0.v <= r_dy[DIFF_W-1] ? -w_v0 : w_v0;
            r_rot0.z <= r_dy[DIFF_W-1] ? $signed(PI_Q60) : '0;
            r_sq_x  <= r_mag_x * r_mag_x;
            r_sq_y  <= r_mag_y * r_mag_y;
            r_rad_sum <= RAD_SUM_W'(r_sq_x) + RAD_SUM_W'(r_sq_y);
        end
    end

    assign w_rot[0] = r_rot0;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
        bd_rot_cell u_rot (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_step (STEP_W'(g)),
            .i_data (w_rot[g]),
            .o_data (w_rot[g+1])
        );
    end

    bd_angle_out u_angle_out (
        .i_clk     (i_clk),
        .i_ce      (w_ce),
        .i_unit    (r_angle_unit),
        .i_angle   (w_rot[ITERATIONS].z),
        .o_bearing (w_bear_raw)
    );

    if (BEAR_DLY > 0) begin : g_dly
        logic [BEARING_W-1:0] r_bear_dly [BEAR_DLY];

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_bear_dly[0] <= w_bear_raw;
                for (int k = 1; k < BEAR_DLY; k++) begin
                    r_bear_dly[k] <= r_bear_dly[k-1];
                end
            end
        end

        assign w_bear_last = r_bear_dly[BEAR_DLY-1];
    end else begin : g_nodly
        assign w_bear_last = w_bear_raw;
    end

    assign w_root[0].rad  = RAD_W'(r_rad_sum);
    assign w_root[0].rem  = '0;
    assign w_root[0].root = '0;

    for (genvar g = 0; g < ROOT_DIGITS; g++) begin : g_root
        bd_root_cell u_root (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_data (w_root[g]),
            .o_data (w_root[g+1])
        );
    end

    // round half up: bump the root when the remainder exceeds it
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_rnd_root <= w_root[ROOT_DIGITS].root;
            r_rnd_up   <= (w_root[ROOT_DIGITS].rem > REM_W'(w_root[ROOT_DIGITS].root));
            r_dist     <= DIST_W'(r_rnd_root) + DIST_W'(r_rnd_up);
        end
    end

    assign w_last_valid   = r_valid[PIPE_DEPTH-1];
    assign w_last_bearing = r_zero[PIPE_DEPTH-1] ? '0 : w_bear_last;

    // output register with skid
    assign w_out_from_skid = r_skid_valid && i_ready;
    assign w_load_out      = !r_skid_valid && (!r_out_valid || i_ready);
    assign w_load_skid     = !r_skid_valid && r_out_valid && !i_ready && w_last_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        priority if (w_out_from_skid) begin
            n_out_valid  = 1'b1;
            n_skid_valid = 1'b0;
        end else if (w_load_out) begin
            n_out_valid  = w_last_valid;
        end else if (w_load_skid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_from_skid) begin
            r_out_bearing <= r_skid_bearing;
            r_out_dist    <= r_skid_dist;
        end else if (w_load_out) begin
            r_out_bearing <= w_last_bearing;
            r_out_dist    <= r_dist;
        end
        if (w_load_skid) begin
            r_skid_bearing <= w_last_bearing;
            r_skid_dist    <= r_dist;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_bearing  = r_out_bearing;
    assign o_distance = r_out_dist;

endmodule

[sv/bd_checker.sv]
module bd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic        [bd_pkg::BEARING_W-1:0] o_bearing,
    input logic        [bd_pkg::DIST_W-1:0]    o_distance
);
    import bd_pkg::*;

    // largest radian code: one full turn rounded to Q29; degree codes stay below it
    localparam logic [63:0] TURN_RAD_Q29 = (TWO_PI_Q60 - 64'd1 + (64'd1 << 30)) >> 31;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bearing) && $stable(o_distance))
        else $error("output beat changed while stalled");

    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_ready) |-> $past(o_valid && !i_ready))
        else $error("ready dropped without an output stall");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> 64'(o_bearing) <= TURN_RAD_Q29)
        else $error("bearing beyond one full turn");

endmodule

bind bearing_and_distance_between_points bd_checker u_bd_checker (.*);

[tb/testbench.sv]
typedef enum logic {
    UNIT_RADIANS = 1'b0,
    UNIT_DEGREES = 1'b1
} angle_unit_e;

typedef struct {
    logic [31:0] bearing;
    logic [32:0] distance;
} polar_fix_t;

localparam int     ROT_STEPS       = 24;
localparam int     GUARD_SHIFT     = 16;
localparam longint EIGHTH_TURN_Q60 = 64'h0C90FDAA22168C23;
localparam longint HALF_TURN_Q60   = 64'h3243F6A8885A308D;
localparam longint FULL_TURN_Q60   = 64'h6487ED5110B4611A;
localparam longint unsigned RAD_TO_DEG_Q32 = 64'd246083499208;
localparam longint unsigned DEG_WRAP_Q23   = 64'd360 << 23;

class polar_tracker;
    angle_unit_e bearing_unit;
    polar_fix_t  expected_fixes[$];
    int          failures;
    longint      atan_q60[ROT_STEPS];

    function new();
        longint acc;
        longint term;
        int     e;
        bearing_unit = UNIT_RADIANS;
        failures     = 0;
        atan_q60[0]  = EIGHTH_TURN_Q60;
        // atan(2^-i) by its series, each term cut to Q60
        for (int i = 1; i < ROT_STEPS; i++) begin
            acc = 0;
            for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
                e    = 60 - i * (2 * k + 1);
                term = longint'((64'd1 << e) / 64'(2 * k + 1));
                acc  = k[0] ? acc - term : acc + term;
            end
            atan_q60[i] = acc;
        end
    endfunction

    function void set_unit(angle_unit_e unit_sel);
        bearing_unit = unit_sel;
    endfunction

    function int pending();
        return expected_fixes.size();
    endfunction

    function polar_fix_t predict_fix(logic signed [31:0] fx, logic signed [31:0] fy,
                                     logic signed [31:0] sx, logic signed [31:0] sy);
        polar_fix_t            fix;
        longint                dx, dy, u, v, z, us, vs;
        logic [63:0]           zu, ax, ay, deg;
        logic [127:0]          prod;
        logic [65:0]           norm2;
        logic [33:0]           root, trial;
        dx = longint'(fx) - longint'(sx);
        dy = longint'(fy) - longint'(sy);
        fix.bearing = '0;
        if (dx != 0 || dy != 0) begin
            u = dy <<< GUARD_SHIFT;
            v = dx <<< GUARD_SHIFT;
            z = 0;
            // fold the lower half plane onto the upper one
            if (u < 0) begin
                u = -u;
                v = -v;
                z = HALF_TURN_Q60;
            end
            for (int i = 0; i < ROT_STEPS; i++) begin
                us = u >>> i;
                vs = v >>> i;
                if (v >= 0) begin
                    u = u + vs;
                    v = v - us;
                    z = z + atan_q60[i];
                end else begin
                    u = u - vs;
                    v = v + us;
                    z = z - atan_q60[i];
                end
            end
            if (z < 0) z = z + FULL_TURN_Q60;
            if (z >= FULL_TURN_Q60) z = z - FULL_TURN_Q60;
            zu = z;
            if (bearing_unit == UNIT_RADIANS) begin
                fix.bearing = 32'((zu + (64'd1 << 30)) >> 31);
            end else begin
                prod = 128'(zu) * 128'(RAD_TO_DEG_Q32);
                deg  = (prod[127:64] + 64'd16) >> 5;
                if (deg >= DEG_WRAP_Q23) deg = deg - DEG_WRAP_Q23;
                fix.bearing = deg[31:0];
            end
        end
        ax    = (dx < 0) ? -dx : dx;
        ay    = (dy < 0) ? -dy : dy;
        norm2 = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
        root  = '0;
        for (int b = 32; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if (67'(trial) * 67'(trial) <= 67'(norm2)) root = trial;
        end
        // round half up: remainder above root means past the midpoint
        if (67'(norm2) - 67'(root) * 67'(root) > 67'(root)) root = root + 1;
        fix.distance = root[32:0];
        return fix;
    endfunction

    function void log_points(logic [31:0] fx, logic [31:0] fy,
                             logic [31:0] sx, logic [31:0] sy);
        expected_fixes.push_back(predict_fix(fx, fy, sx, sy));
    endfunction

    function void check_fix(logic [31:0] bearing, logic [32:0] distance);
        polar_fix_t want;
        if (expected_fixes.size() == 0) begin
            $error("unexpected result: bearing %0d, distance %0d", bearing, distance);
            failures++;
            return;
        end
        want = expected_fixes.pop_front();
        if (bearing !== want.bearing) begin
            $error("bearing mismatch: expected %0d, actual %0d", want.bearing, bearing);
            failures++;
        end
        if (distance !== want.distance) begin
            $error("distance mismatch: expected %0d, actual %0d", want.distance, distance);
            failures++;
        end
    endfunction
endclass

module testbench;

    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 100;
    localparam int NUM_PHASES    = 4;
    localparam int DRAIN_CYCLES  = 80;
    localparam int STALL_LIMIT   = 4000;
    localparam logic [31:0] Q_MAX = 32'h7FFFFFFF;
    localparam logic [31:0] Q_MIN = 32'h80000000;
    localparam logic [31:0] Q_ONE = 32'h00010000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_first_x = '0;
    logic [31:0] i_first_y = '0;
    logic [31:0] i_second_x = '0;
    logic [31:0] i_second_y = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [bd_pkg::BEARING_W-1:0] o_bearing;
    logic [bd_pkg::DIST_W-1:0]    o_distance;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    logic [5:0]  stall_cnt = '0;
    logic [1:0]  stall_mode = '0;

    polar_tracker book = new();

    bearing_and_distance_between_points DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_first_x   (i_first_x),
        .i_first_y   (i_first_y),
        .i_second_x  (i_second_x),
        .i_second_y  (i_second_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_bearing   (o_bearing),
        .o_distance  (o_distance),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver: pick a new stall pattern whenever stall_cnt reaches zero
    always @(posedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
        end
        stall_cnt <= stall_cnt - 1'b1;
        case (stall_mode)
            2'd0: i_ready <= 1'b1;
            2'd1: i_ready <= 1'($urandom_range(0, 1));
            2'd2: i_ready <= (stall_cnt[2:0] == 3'd0);
            default: i_ready <= (stall_cnt < 6'd16);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            book.check_fix(o_bearing, o_distance);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic push_points(logic [31:0] fx, logic [31:0] fy,
                               logic [31:0] sx, logic [31:0] sy);
        i_valid    <= 1'b1;
        i_first_x  <= fx;
        i_first_y  <= fy;
        i_second_x <= sx;
        i_second_y <= sy;
        do @(posedge i_clk); while (!o_ready);
        book.log_points(fx, fy, sx, sy);
    endtask

    // hold off the sender until every pending fix is out
    task automatic drain_fixes();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (book.pending() != 0);
    endtask

    task automatic write_angle_unit(angle_unit_e unit_sel);
        drain_fixes();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= unit_sel;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        book.set_unit(unit_sel);
    endtask

    function automatic logic [31:0] corner_value();
        case ($urandom_range(0, 5))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return '1;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_points(output logic [31:0] fx, output logic [31:0] fy,
                                 output logic [31:0] sx, output logic [31:0] sy);
        logic [31:0] d;
        fx = $urandom;
        fy = $urandom;
        sx = $urandom;
        sy = $urandom;
        case ($urandom_range(0, 9))
            4: begin
                sx = fx - 32'($urandom_range(0, 2000)) + 32'd1000;
                sy = fy - 32'($urandom_range(0, 2000)) + 32'd1000;
            end
            5: begin
                if ($urandom_range(0, 1)) sx = fx;
                else sy = fy;
            end
            6: begin
                sx = fx;
                sy = fy;
            end
            7: begin
                fx = corner_value();
                fy = corner_value();
                sx = corner_value();
                sy = corner_value();
            end
            8: begin
                d  = 32'($urandom_range(1, 1 << 20));
                sx = fx - d;
                sy = $urandom_range(0, 1) ? fy - d : fy + d;
            end
            9: begin
                fx = 32'($urandom_range(0, 131072)) - 32'd65536;
                fy = 32'($urandom_range(0, 131072)) - 32'd65536;
                sx = 32'($urandom_range(0, 131072)) - 32'd65536;
                sy = 32'($urandom_range(0, 131072)) - 32'd65536;
            end
            default: ;
        endcase
    endtask

    task automatic run_directed();
        push_points('0, '0, '0, '0);
        push_points(Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        push_points(Q_MAX, Q_MAX, Q_MIN, Q_MIN);
        push_points(Q_MIN, Q_MIN, Q_MAX, Q_MAX);
        push_points(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
        push_points(Q_MIN, Q_MAX, Q_MAX, Q_MIN);
        // unit steps along each axis, then full-range spans along each axis
        push_points('0, 32'd1, '0, '0);
        push_points('0, '1, '0, '0);
        push_points(32'd1, '0, '0, '0);
        push_points('1, '0, '0, '0);
        push_points(Q_MAX, '0, Q_MIN, '0);
        push_points(Q_MIN, '0, Q_MAX, '0);
        push_points('0, Q_MAX, '0, Q_MIN);
        push_points('0, Q_MIN, '0, Q_MAX);
        // one point per quadrant, then small diagonals and alternating bit patterns
        push_points(3 * Q_ONE, 4 * Q_ONE, '0, '0);
        push_points(3 * Q_ONE, -4 * Q_ONE, '0, '0);
        push_points(-3 * Q_ONE, -4 * Q_ONE, '0, '0);
        push_points(-3 * Q_ONE, 4 * Q_ONE, '0, '0);
        push_points(32'd1, 32'd1, '0, '0);
        push_points('1, 32'd1, '0, '0);
        push_points(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA);
        push_points(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555);
    endtask

    task automatic run_random(int count);
        logic [31:0] fx, fy, sx, sy;
        int          burst_left;
        int          gap;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                drain_fixes();
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            random_points(fx, fy, sx, sy);
            push_points(fx, fy, sx, sy);
            burst_left--;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_angle_unit(angle_unit_e'(p[0]));
            if (p < 2) run_directed();
            run_random(RANDOM_ITEMS);
        end
        drain_fixes();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.failures == 0 && book.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/bd_pkg.sv
sv/bd_rot_cell.sv
sv/bd_root_cell.sv
sv/bd_angle_out.sv
sv/bearing_and_distance_between_points.sv
sv/bd_checker.sv
tb/testbench.sv
